// ===== src/strongly_connected_component_sizes_top_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef STRONGLY_CONNECTED_COMPONENT_SIZES_TOP_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENT_SIZES_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCC_ASSERT(lbl, prop, msg)
`define SCC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/scc_pkg.sv =====
package scc_pkg;

  localparam int MAX_V     = 1024;
  localparam int MAX_E     = 4096;
  localparam int TOP_N     = 5;
  localparam int VW        = 10;
  localparam int EAW       = 12;
  localparam int ECW       = 13;
  localparam int OAW       = 11;
  localparam int OFF_DEPTH = MAX_V + 2;
  localparam int SZW       = 11;
  localparam int RKW       = 3;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LDA, S_LDB, S_PFXA, S_PFXB, S_PLCA, S_PLCB, S_PLCC,
    S_VCLR, S_O0A, S_O0B, S_O1A, S_O1B, S_O1C, S_PUSH1, S_PUSH2, S_CHK,
    S_W1, S_W2, S_POP1, S_EMIT
  } state_t;

endpackage

// ===== src/strongly_connected_component_sizes_top.sv =====
// Strongly connected component sizes.
// The input channel carries one graph as a run of items: an edge from the
// tail vertex to the head vertex, or a lone vertex (tuser low); edges past
// 4096 are dropped and flagged. The item with tlast set closes the graph.
// Processing then runs in one sequencer around single-port memories:
// a prefix pass over the 1026 offset entries, a pass that builds the
// lists edge by edge, a clear of the visited marks before each search
// pass, and for each search a walk over its vertices and edges.
// Up to five results follow, largest component first, tlast on the last.
// While the receiver stalls the current result holds on the output.
// After the last result, and after reset, a clearing pass sweeps the
// offset and mark memories; no item is accepted meanwhile.
`include "strongly_connected_component_sizes_top_macros.svh"
module strongly_connected_component_sizes_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // tail_vertex, head_vertex, zero fill
  input  logic        in_tuser,   // has_edge
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // component_size, size_rank, edges_dropped, zero fill
  output logic        out_tlast
);
  import scc_pkg::*;

  logic [VW-1:0]  etl_mem [MAX_E];
  logic [VW-1:0]  ehd_mem [MAX_E];
  logic [VW-1:0]  fl_mem  [MAX_E];
  logic [VW-1:0]  rl_mem  [MAX_E];
  logic [ECW-1:0] offf_mem [OFF_DEPTH];
  logic [ECW-1:0] offr_mem [OFF_DEPTH];
  logic           pres_mem [MAX_V];
  logic           vis_mem  [MAX_V];
  logic [VW-1:0]  fin_mem  [MAX_V];
  logic [VW+ECW-1:0] stk_mem [MAX_V];

  logic [VW-1:0]  etl_rd, ehd_rd, fl_rd, rl_rd, fin_rd;
  logic [ECW-1:0] offf_rd, offr_rd;
  logic           pres_rd, vis_rd;
  logic [VW+ECW-1:0] stk_rd;

  logic           e_we, e_re, fl_we, rl_we, l_re, off_re, offf_we, offr_we;
  logic           pres_we, pres_re, vis_we, vis_re, fin_we, fin_re, stk_we, stk_re;
  logic [EAW-1:0] e_wa, e_ra, fl_wa, rl_wa, l_ra;
  logic [VW-1:0]  fl_wd, rl_wd, fin_wd;
  logic [OAW-1:0] offf_ra, offr_ra, offf_wa, offr_wa;
  logic [ECW-1:0] offf_wd, offr_wd;
  logic [VW-1:0]  pres_wa, pres_ra, vis_wa, vis_ra, fin_wa, fin_ra, stk_wa, stk_ra;
  logic           pres_wd, vis_wd;
  logic [VW+ECW-1:0] stk_wd;

  state_t         state_r, state_nxt;
  logic [VW-1:0]  tail_r, tail_nxt, head_r, head_nxt, vidx_r, vidx_nxt;
  logic [VW-1:0]  topv_r, topv_nxt, w_r, w_nxt;
  logic           last_r, last_nxt, ovf_r, ovf_nxt, pass_r, pass_nxt;
  logic [ECW-1:0] etot_r, etot_nxt, sumf_r, sumf_nxt, sumr_r, sumr_nxt;
  logic [ECW-1:0] topc_r, topc_nxt, tope_r, tope_nxt;
  logic [OAW-1:0] k_r, k_nxt, fc_r, fc_nxt, i_r, i_nxt, sp_r, sp_nxt;
  logic [EAW-1:0] e_r, e_nxt;
  logic [SZW-1:0] size_r, size_nxt;
  logic [SZW-1:0] tops_r [TOP_N];
  logic [SZW-1:0] tops_nxt [TOP_N];
  logic [RKW-1:0] r_r, r_nxt;

  logic [ECW-1:0] off_sel;
  logic [VW-1:0]  list_sel, sv;
  logic           start_walk, is_last;
  logic [SZW-1:0] ins_size;
  logic           do_insert;
  logic [TOP_N-1:0] lt;

  assign off_sel  = pass_r ? offf_rd : offr_rd;
  assign list_sel = pass_r ? fl_rd : rl_rd;

  always_ff @(posedge clk) begin
    if (e_we) begin
      etl_mem[e_wa] <= tail_r;
      ehd_mem[e_wa] <= head_r;
    end
    if (e_re) begin
      etl_rd <= etl_mem[e_ra];
      ehd_rd <= ehd_mem[e_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (fl_we) fl_mem[fl_wa] <= fl_wd;
    if (rl_we) rl_mem[rl_wa] <= rl_wd;
    if (l_re) begin
      fl_rd <= fl_mem[l_ra];
      rl_rd <= rl_mem[l_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (offf_we) offf_mem[offf_wa] <= offf_wd;
    if (offr_we) offr_mem[offr_wa] <= offr_wd;
    if (off_re) begin
      offf_rd <= offf_mem[offf_ra];
      offr_rd <= offr_mem[offr_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (pres_we) pres_mem[pres_wa] <= pres_wd;
    if (pres_re) pres_rd <= pres_mem[pres_ra];
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (vis_re) vis_rd <= vis_mem[vis_ra];
    if (fin_we) fin_mem[fin_wa] <= fin_wd;
    if (fin_re) fin_rd <= fin_mem[fin_ra];
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      k_r     <= '0;
      etot_r  <= '0;
      ovf_r   <= 1'b0;
      sp_r    <= '0;
      for (int j = 0; j < TOP_N; j++) tops_r[j] <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      etot_r  <= etot_nxt;
      ovf_r   <= ovf_nxt;
      sp_r    <= sp_nxt;
      for (int j = 0; j < TOP_N; j++) tops_r[j] <= tops_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    tail_r <= tail_nxt;
    head_r <= head_nxt;
    last_r <= last_nxt;
    sumf_r <= sumf_nxt;
    sumr_r <= sumr_nxt;
    e_r    <= e_nxt;
    pass_r <= pass_nxt;
    vidx_r <= vidx_nxt;
    fc_r   <= fc_nxt;
    i_r    <= i_nxt;
    topv_r <= topv_nxt;
    topc_r <= topc_nxt;
    tope_r <= tope_nxt;
    w_r    <= w_nxt;
    size_r <= size_nxt;
    r_r    <= r_nxt;
  end

  always_comb begin
    is_last = 1'b1;
    for (int j = 1; j < TOP_N; j++) begin
      if (RKW'(j) == r_r + RKW'(1) && tops_r[j] != '0) is_last = 1'b0;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_EMIT) && (tops_r[0] != '0);
  assign out_tlast  = is_last;
  assign out_tdata  = {1'b0, ovf_r, r_r, tops_r[r_r]};

  always_comb begin
    state_nxt = state_r;
    tail_nxt = tail_r; head_nxt = head_r; last_nxt = last_r;
    etot_nxt = etot_r; ovf_nxt = ovf_r; k_nxt = k_r;
    sumf_nxt = sumf_r; sumr_nxt = sumr_r; e_nxt = e_r; pass_nxt = pass_r;
    vidx_nxt = vidx_r; fc_nxt = fc_r; i_nxt = i_r; sp_nxt = sp_r;
    topv_nxt = topv_r; topc_nxt = topc_r; tope_nxt = tope_r; w_nxt = w_r;
    size_nxt = size_r; r_nxt = r_r;
    for (int j = 0; j < TOP_N; j++) tops_nxt[j] = tops_r[j];
    e_we = 1'b0; e_re = 1'b0; e_wa = '0; e_ra = '0;
    fl_we = 1'b0; rl_we = 1'b0; l_re = 1'b0; fl_wa = '0; rl_wa = '0; l_ra = '0;
    fl_wd = '0; rl_wd = '0;
    off_re = 1'b0; offf_we = 1'b0; offr_we = 1'b0;
    offf_ra = '0; offr_ra = '0; offf_wa = '0; offr_wa = '0; offf_wd = '0; offr_wd = '0;
    pres_we = 1'b0; pres_re = 1'b0; pres_wa = '0; pres_ra = '0; pres_wd = 1'b0;
    vis_we = 1'b0; vis_re = 1'b0; vis_wa = '0; vis_ra = '0; vis_wd = 1'b0;
    fin_we = 1'b0; fin_re = 1'b0; fin_wa = '0; fin_ra = '0; fin_wd = '0;
    stk_we = 1'b0; stk_re = 1'b0; stk_wa = '0; stk_ra = '0; stk_wd = '0;
    start_walk = 1'b0; sv = '0;
    do_insert = 1'b0; ins_size = size_r + SZW'(1);
    for (int j = 0; j < TOP_N; j++) lt[j] = tops_r[j] < ins_size;

    unique case (state_r)
      S_CLR: begin
        offf_we = 1'b1; offr_we = 1'b1; offf_wa = k_r; offr_wa = k_r;
        if (k_r < OAW'(MAX_V)) begin
          pres_we = 1'b1; pres_wa = k_r[VW-1:0];
          vis_we = 1'b1; vis_wa = k_r[VW-1:0];
        end
        k_nxt = k_r + OAW'(1);
        if (k_r == OAW'(OFF_DEPTH - 1)) begin
          etot_nxt = '0;
          ovf_nxt = 1'b0;
          for (int j = 0; j < TOP_N; j++) tops_nxt[j] = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          tail_nxt = in_tdata[VW-1:0];
          head_nxt = in_tdata[2*VW-1:VW];
          last_nxt = in_tlast;
          pres_we = 1'b1; pres_wa = in_tdata[VW-1:0]; pres_wd = 1'b1;
          k_nxt = '0; sumf_nxt = '0; sumr_nxt = '0;
          if (in_tuser) state_nxt = S_LDA;
          else if (in_tlast) state_nxt = S_PFXA;
        end
      end
      S_LDA: begin
        pres_we = 1'b1; pres_wa = head_r; pres_wd = 1'b1;
        if (etot_r < ECW'(MAX_E)) begin
          e_we = 1'b1; e_wa = etot_r[EAW-1:0];
          off_re = 1'b1;
          offf_ra = {1'b0, tail_r} + OAW'(1);
          offr_ra = {1'b0, head_r} + OAW'(1);
          state_nxt = S_LDB;
        end else begin
          ovf_nxt = 1'b1;
          state_nxt = last_r ? S_PFXA : S_IDLE;
        end
      end
      S_LDB: begin
        offf_we = 1'b1; offr_we = 1'b1;
        offf_wa = {1'b0, tail_r} + OAW'(1);
        offr_wa = {1'b0, head_r} + OAW'(1);
        offf_wd = offf_rd + ECW'(1);
        offr_wd = offr_rd + ECW'(1);
        etot_nxt = etot_r + ECW'(1);
        state_nxt = last_r ? S_PFXA : S_IDLE;
      end
      S_PFXA: begin
        off_re = 1'b1; offf_ra = k_r; offr_ra = k_r;
        state_nxt = S_PFXB;
      end
      S_PFXB: begin
        offf_we = 1'b1; offr_we = 1'b1; offf_wa = k_r; offr_wa = k_r;
        offf_wd = sumf_r + offf_rd;
        offr_wd = sumr_r + offr_rd;
        sumf_nxt = offf_wd;
        sumr_nxt = offr_wd;
        k_nxt = k_r + OAW'(1);
        e_nxt = EAW'(etot_r - ECW'(1));
        pass_nxt = 1'b0;
        if (k_r == OAW'(OFF_DEPTH - 1)) begin
          k_nxt = '0;
          state_nxt = (etot_r == '0) ? S_VCLR : S_PLCA;
        end else begin
          state_nxt = S_PFXA;
        end
      end
      S_PLCA: begin
        e_re = 1'b1; e_ra = e_r;
        state_nxt = S_PLCB;
      end
      S_PLCB: begin
        off_re = 1'b1;
        offf_ra = {1'b0, etl_rd} + OAW'(1);
        offr_ra = {1'b0, ehd_rd} + OAW'(1);
        state_nxt = S_PLCC;
      end
      S_PLCC: begin
        offf_we = 1'b1; offr_we = 1'b1;
        offf_wa = {1'b0, etl_rd} + OAW'(1);
        offr_wa = {1'b0, ehd_rd} + OAW'(1);
        offf_wd = offf_rd - ECW'(1);
        offr_wd = offr_rd - ECW'(1);
        fl_we = 1'b1; fl_wa = offf_wd[EAW-1:0]; fl_wd = ehd_rd;
        rl_we = 1'b1; rl_wa = offr_wd[EAW-1:0]; rl_wd = etl_rd;
        e_nxt = e_r - EAW'(1);
        k_nxt = '0;
        state_nxt = (e_r == '0) ? S_VCLR : S_PLCA;
      end
      S_VCLR: begin
        vis_we = 1'b1; vis_wa = k_r[VW-1:0];
        k_nxt = k_r + OAW'(1);
        if (k_r == OAW'(MAX_V - 1)) begin
          vidx_nxt = VW'(MAX_V - 1);
          i_nxt = fc_r;
          if (!pass_r) fc_nxt = '0;
          state_nxt = pass_r ? S_O1A : S_O0A;
        end
      end
      S_O0A: begin
        pres_re = 1'b1; pres_ra = vidx_r;
        vis_re = 1'b1; vis_ra = vidx_r;
        state_nxt = S_O0B;
      end
      S_O0B: begin
        if (pres_rd && !vis_rd) begin
          start_walk = 1'b1; sv = vidx_r;
        end else if (vidx_r == '0) begin
          pass_nxt = 1'b1; k_nxt = '0; state_nxt = S_VCLR;
        end else begin
          vidx_nxt = vidx_r - VW'(1); state_nxt = S_O0A;
        end
      end
      S_O1A: begin
        if (i_r == '0) begin
          r_nxt = '0; state_nxt = S_EMIT;
        end else begin
          fin_re = 1'b1; fin_ra = VW'(i_r - OAW'(1));
          state_nxt = S_O1B;
        end
      end
      S_O1B: begin
        vis_re = 1'b1; vis_ra = fin_rd;
        state_nxt = S_O1C;
      end
      S_O1C: begin
        if (!vis_rd) begin
          start_walk = 1'b1; sv = fin_rd;
        end else begin
          i_nxt = i_r - OAW'(1); state_nxt = S_O1A;
        end
      end
      S_PUSH1: begin
        topc_nxt = off_sel;
        off_re = 1'b1;
        offf_ra = {1'b0, w_r} + OAW'(2);
        offr_ra = offf_ra;
        state_nxt = S_PUSH2;
      end
      S_PUSH2: begin
        tope_nxt = off_sel;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (topc_r < tope_r) begin
          l_re = 1'b1; l_ra = topc_r[EAW-1:0];
          topc_nxt = topc_r + ECW'(1);
          state_nxt = S_W1;
        end else begin
          if (!pass_r && fc_r < OAW'(MAX_V)) begin
            fin_we = 1'b1; fin_wa = fc_r[VW-1:0]; fin_wd = topv_r;
            fc_nxt = fc_r + OAW'(1);
          end
          size_nxt = size_r + SZW'(1);
          sp_nxt = sp_r - OAW'(1);
          if (sp_r == OAW'(1)) begin
            if (!pass_r) begin
              if (vidx_r == '0) begin
                pass_nxt = 1'b1; k_nxt = '0; state_nxt = S_VCLR;
              end else begin
                vidx_nxt = vidx_r - VW'(1); state_nxt = S_O0A;
              end
            end else begin
              do_insert = 1'b1;
              i_nxt = i_r - OAW'(1);
              state_nxt = S_O1A;
            end
          end else begin
            stk_re = 1'b1; stk_ra = VW'(sp_r - OAW'(2));
            state_nxt = S_POP1;
          end
        end
      end
      S_W1: begin
        w_nxt = list_sel;
        vis_re = 1'b1; vis_ra = list_sel;
        state_nxt = S_W2;
      end
      S_W2: begin
        if (!vis_rd && sp_r < OAW'(MAX_V)) begin
          vis_we = 1'b1; vis_wa = w_r; vis_wd = 1'b1;
          stk_we = 1'b1; stk_wa = VW'(sp_r - OAW'(1)); stk_wd = {topv_r, topc_r};
          topv_nxt = w_r;
          sp_nxt = sp_r + OAW'(1);
          off_re = 1'b1;
          offf_ra = {1'b0, w_r} + OAW'(1);
          offr_ra = offf_ra;
          state_nxt = S_PUSH1;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_POP1: begin
        topv_nxt = stk_rd[VW+ECW-1:ECW];
        topc_nxt = stk_rd[ECW-1:0];
        off_re = 1'b1;
        offf_ra = {1'b0, stk_rd[VW+ECW-1:ECW]} + OAW'(2);
        offr_ra = offf_ra;
        state_nxt = S_PUSH2;
      end
      S_EMIT: begin
        k_nxt = '0;
        if (tops_r[0] == '0) begin
          state_nxt = S_CLR;
        end else if (out_tready) begin
          if (is_last) state_nxt = S_CLR;
          else r_nxt = r_r + RKW'(1);
        end
      end
      default: state_nxt = S_CLR;
    endcase

    if (start_walk) begin
      vis_we = 1'b1; vis_wa = sv; vis_wd = 1'b1;
      w_nxt = sv; topv_nxt = sv; sp_nxt = OAW'(1); size_nxt = '0;
      off_re = 1'b1;
      offf_ra = {1'b0, sv} + OAW'(1);
      offr_ra = offf_ra;
      state_nxt = S_PUSH1;
    end

    if (do_insert) begin
      for (int j = 0; j < TOP_N; j++) begin
        if (lt[j]) begin
          if (j == 0) tops_nxt[j] = ins_size;
          else if (!lt[j-1]) tops_nxt[j] = ins_size;
          else tops_nxt[j] = tops_r[j-1];
        end
      end
    end
  end

  `SCC_ASSERT(a_out_nonzero, out_tvalid |-> (out_tdata[SZW-1:0] != '0), "zero size emitted")
  `SCC_ASSERT(a_sp_bound, sp_r <= OAW'(MAX_V), "walk stack overrun")
  `SCC_ASSERT(a_excl, !(in_tready && out_tvalid), "input open while results pending")
  `SCC_ASSERT(a_clr_after, (out_tvalid && out_tready && out_tlast) |=> (state_r == S_CLR),
              "no clear after last result")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import scc_pkg::*;

  localparam int WATCHDOG_LIMIT = 250000;
  localparam int HOLD_CYCLES    = 4000;

  typedef struct packed {
    logic [SZW-1:0] size;
    logic [RKW-1:0] rank;
    logic           dropped;
    logic           last;
  } comp_size_t;

  typedef struct {
    int tail;
    int head;
    bit has_edge;
    bit last;
    int typed_count;
    int typed_size;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  strongly_connected_component_sizes_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  comp_size_t sizes_due[$];
  bit         vertex_seen[MAX_V];
  int         edge_tails[$];
  int         edge_heads[$];
  bit         edges_lost;
  int         adj_off[2][MAX_V+1];
  int         adj_list[2][MAX_E];
  bit         walked[MAX_V];
  int         finish_order[MAX_V];
  int         finish_total;
  int         stk_vertex[MAX_V];
  int         stk_cursor[MAX_V];

  int errors = 0;
  int idle_in = 0;
  int idle_out = 0;
  int graphs_sent = 0;
  int sizes_checked = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %0s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Direction 0 groups edges by tail (forward), direction 1 by head (reversed).
  function automatic void build_adjacency(input int dir);
    int cnt[MAX_V+1];
    int k;
    int e;
    int key;
    for (k = 0; k <= MAX_V; k++) cnt[k] = 0;
    for (e = 0; e < edge_tails.size(); e++) begin
      key = dir ? edge_heads[e] : edge_tails[e];
      cnt[key+1]++;
    end
    for (k = 1; k <= MAX_V; k++) cnt[k] += cnt[k-1];
    for (k = 0; k <= MAX_V; k++) adj_off[dir][k] = cnt[k];
    for (e = 0; e < edge_tails.size(); e++) begin
      key = dir ? edge_heads[e] : edge_tails[e];
      adj_list[dir][cnt[key]] = dir ? edge_tails[e] : edge_heads[e];
      cnt[key]++;
    end
  endfunction

  function automatic int depth_walk(input int start, input int dir, input bit record);
    int sp;
    int count;
    int v;
    int w;
    count = 0;
    walked[start] = 1'b1;
    stk_vertex[0] = start;
    stk_cursor[0] = adj_off[dir][start];
    sp = 1;
    while (sp > 0) begin
      v = stk_vertex[sp-1];
      if (stk_cursor[sp-1] < adj_off[dir][v+1]) begin
        w = adj_list[dir][stk_cursor[sp-1]];
        stk_cursor[sp-1]++;
        if (!walked[w]) begin
          walked[w] = 1'b1;
          stk_vertex[sp] = w;
          stk_cursor[sp] = adj_off[dir][w];
          sp++;
        end
      end else begin
        sp--;
        if (record) begin
          finish_order[finish_total] = v;
          finish_total++;
        end
        count++;
      end
    end
    return count;
  endfunction

  function automatic void predict_component_sizes(input int tail, input int head,
                                                  input bit has_edge, input bit last);
    int best[TOP_N];
    int v;
    int i;
    int j;
    int sz;
    int n;
    comp_size_t r;
    vertex_seen[tail] = 1'b1;
    if (has_edge) begin
      vertex_seen[head] = 1'b1;
      if (edge_tails.size() < MAX_E) begin
        edge_tails = {edge_tails, tail};
        edge_heads = {edge_heads, head};
      end else begin
        edges_lost = 1'b1;
      end
    end
    if (!last) return;
    build_adjacency(0);
    build_adjacency(1);
    for (i = 0; i < TOP_N; i++) best[i] = 0;
    finish_total = 0;
    for (v = 0; v < MAX_V; v++) walked[v] = 1'b0;
    for (v = MAX_V - 1; v >= 0; v--)
      if (vertex_seen[v] && !walked[v]) void'(depth_walk(v, 1, 1'b1));
    for (v = 0; v < MAX_V; v++) walked[v] = 1'b0;
    for (i = finish_total - 1; i >= 0; i--) begin
      if (!walked[finish_order[i]]) begin
        sz = depth_walk(finish_order[i], 0, 1'b0);
        if (sz > best[TOP_N-1]) begin
          j = TOP_N - 1;
          while (j > 0 && best[j-1] < sz) begin
            best[j] = best[j-1];
            j--;
          end
          best[j] = sz;
        end
      end
    end
    n = 0;
    while (n < TOP_N && best[n] != 0) n++;
    for (i = 0; i < n; i++) begin
      r.size = (best[i] > 2047) ? 11'd2047 : best[i][SZW-1:0];
      r.rank = i[RKW-1:0];
      r.dropped = edges_lost;
      r.last = (i == n - 1);
      sizes_due = {sizes_due, r};
    end
    for (v = 0; v < MAX_V; v++) vertex_seen[v] = 1'b0;
    edge_tails.delete();
    edge_heads.delete();
    edges_lost = 1'b0;
  endfunction

  task automatic send_item(input int tail, input int head, input bit has_edge,
                           input bit last);
    while ($urandom_range(99) < idle_in) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, head[VW-1:0], tail[VW-1:0]};
    in_tuser <= has_edge;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (last) graphs_sent++;
  endtask

  task automatic send_random_graph(input int max_items);
    int k;
    int i;
    int span;
    int t;
    int h;
    bit with_edge;
    k = $urandom_range(2, max_items);
    span = ($urandom_range(99) < 80) ? $urandom_range(3, 15) : MAX_V - 1;
    for (i = 0; i < k; i++) begin
      t = $urandom_range(span);
      h = $urandom_range(span);
      with_edge = ($urandom_range(99) < 85);
      send_item(t, h, with_edge, i == k - 1);
      predict_component_sizes(t, h, with_edge, i == k - 1);
    end
  endtask

  always @(posedge clk) begin
    comp_size_t got;
    comp_size_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[10:0], out_tdata[13:11], out_tdata[14], out_tlast};
      if (sizes_due.size() == 0) begin
        report_mismatch("unexpected component size", got.size, -1);
      end else begin
        want = sizes_due.pop_front();
        if (got.size != want.size) report_mismatch("component_size", got.size, want.size);
        if (got.rank != want.rank) report_mismatch("size_rank", got.rank, want.rank);
        if (got.dropped != want.dropped)
          report_mismatch("edges_dropped", got.dropped, want.dropped);
        if (got.last != want.last) report_mismatch("last_result", got.last, want.last);
      end
      sizes_checked++;
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("strongly_connected_component_sizes_top regression: fail");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= idle_out);
    end
  end

  stim_row_t directed_rows[18] = '{
    '{0, 0, 1'b0, 1'b1, 1, 1},
    '{1023, 1023, 1'b0, 1'b1, 1, 1},
    '{5, 5, 1'b1, 1'b1, 1, 1},
    '{0, 1023, 1'b1, 1'b0, -1, 0},
    '{1023, 0, 1'b1, 1'b1, 1, 2},
    '{10, 0, 1'b0, 1'b0, -1, 0},
    '{11, 0, 1'b0, 1'b0, -1, 0},
    '{12, 0, 1'b0, 1'b0, -1, 0},
    '{13, 0, 1'b0, 1'b0, -1, 0},
    '{14, 0, 1'b0, 1'b0, -1, 0},
    '{15, 0, 1'b0, 1'b1, 5, 1},
    '{1, 2, 1'b1, 1'b0, -1, 0},
    '{2, 3, 1'b1, 1'b0, -1, 0},
    '{3, 1, 1'b1, 1'b0, -1, 0},
    '{4, 5, 1'b1, 1'b0, -1, 0},
    '{5, 4, 1'b1, 1'b0, -1, 0},
    '{6, 0, 1'b0, 1'b0, -1, 0},
    '{3, 4, 1'b1, 1'b1, -1, 0}
  };

  initial begin
    int i;
    int phase;
    int target;
    comp_size_t typed;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    idle_in = 15;
    idle_out = 52;
    foreach (directed_rows[row]) begin
      send_item(directed_rows[row].tail, directed_rows[row].head,
                directed_rows[row].has_edge, directed_rows[row].last);
      predict_component_sizes(directed_rows[row].tail, directed_rows[row].head,
                              directed_rows[row].has_edge, directed_rows[row].last);
      if (directed_rows[row].typed_count >= 0) begin
        for (i = 0; i < directed_rows[row].typed_count; i++) void'(sizes_due.pop_back());
        for (i = 0; i < directed_rows[row].typed_count; i++) begin
          typed.size = directed_rows[row].typed_size[SZW-1:0];
          typed.rank = i[RKW-1:0];
          typed.dropped = 1'b0;
          typed.last = (i == directed_rows[row].typed_count - 1);
          sizes_due = {sizes_due, typed};
        end
      end
    end
    for (phase = 0; phase < 3; phase++) begin
      idle_in = (phase == 0) ? 15 : (phase == 1) ? 52 : 0;
      idle_out = (phase == 0) ? 52 : (phase == 1) ? 15 : 0;
      if (phase == 2) hold_req = 1'b1;
      target = items_sent + 80;
      while (items_sent < target) send_random_graph(12);
    end
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    wait (sizes_due.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d graphs in %0d items, from lone vertices to sparse wide graphs.",
             graphs_sent, items_sent);
    $display("Checked %0d component sizes under varied input and output stalls.",
             sizes_checked);
    if (errors == 0) begin
      $display("strongly_connected_component_sizes_top regression: pass");
    end else begin
      $display("strongly_connected_component_sizes_top regression: fail");
    end
    $finish;
  end

endmodule
